/* rtl/rc_pulse_to_differential_drive_macros.svh */
// Assertion helpers for the RTL.
`ifndef RC_PULSE_TO_DIFFERENTIAL_DRIVE_MACROS_SVH
`define RC_PULSE_TO_DIFFERENTIAL_DRIVE_MACROS_SVH

// Check an implication within the same cycle.
`define RCPD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle.
`define RCPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rcpd_pkg.sv */
`default_nettype none

package rcpd_pkg;

    localparam int STAMP_BITS_DEF = 16;
    localparam int IN_W           = 16;
    localparam int DB_W           = 10;
    localparam int POS_W          = 11;
    localparam int DUTY_W         = 11;
    localparam int SUM_W          = 16;
    localparam int MAG_W          = 15;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int DIV_NUM_W_DEF  = STAMP_BITS_DEF + POS_W;

    localparam logic [CFG_INDEX_W-1:0] REG_VERT_IN_MIN    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VERT_IN_MAX    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HORIZ_IN_MIN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HORIZ_IN_MAX   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_BAND      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_POSITION_LIMIT = 3'd5;

    localparam logic [IN_W-1:0] VERT_IN_MIN_RST    = 16'd1045;
    localparam logic [IN_W-1:0] VERT_IN_MAX_RST    = 16'd2065;
    localparam logic [IN_W-1:0] HORIZ_IN_MIN_RST   = 16'd1130;
    localparam logic [IN_W-1:0] HORIZ_IN_MAX_RST   = 16'd1945;
    localparam logic [DB_W-1:0] DEAD_BAND_RST      = 10'd30;
    localparam logic [DB_W-1:0] POSITION_LIMIT_RST = 10'd500;

    // mix = (15 v +/- 4 h) / 10, the divide done as a multiply by 52429 / 2^19
    localparam logic signed [SUM_W-1:0] MIX_V_GAIN = 16'sd15;
    localparam logic signed [SUM_W-1:0] MIX_H_GAIN = 16'sd4;
    localparam logic [CFG_DATA_W-1:0]   MIX_RECIP  = 16'd52429;
    localparam int                      MIX_SHIFT  = 19;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_WAIT,
        ST_SHAPE,
        ST_SUM,
        ST_MIX_L,
        ST_MIX_R,
        ST_OUT
    } rcpd_state_t;

endpackage

`default_nettype wire

/* rtl/rcpd_if.sv */
`default_nettype none

interface rcpd_capture_if #(
    parameter int STAMP_BITS = rcpd_pkg::STAMP_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  channel;
    logic [STAMP_BITS-1:0] stamp;

    modport source (output valid, output channel, output stamp, input ready);
    modport sink   (input valid, input channel, input stamp, output ready);
endinterface

interface rcpd_drive_if;
    logic                                    valid;
    logic                                    ready;
    logic        [rcpd_pkg::DUTY_W-1:0]      left_forward;
    logic        [rcpd_pkg::DUTY_W-1:0]      left_reverse;
    logic        [rcpd_pkg::DUTY_W-1:0]      right_forward;
    logic        [rcpd_pkg::DUTY_W-1:0]      right_reverse;
    logic                                    counter_clear;
    logic signed [rcpd_pkg::POS_W-1:0]       vert_position;
    logic signed [rcpd_pkg::POS_W-1:0]       horiz_position;

    modport source (
        output valid, input ready,
        output left_forward, output left_reverse,
        output right_forward, output right_reverse,
        output counter_clear, output vert_position, output horiz_position
    );
    modport sink (
        input valid, output ready,
        input left_forward, input left_reverse,
        input right_forward, input right_reverse,
        input counter_clear, input vert_position, input horiz_position
    );
endinterface

`default_nettype wire

/* rtl/rcpd_div.sv */
`default_nettype none

module rcpd_div #(
    parameter int NUM_W = rcpd_pkg::DIV_NUM_W_DEF,
    parameter int DEN_W = rcpd_pkg::IN_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    dividend,
    input  logic [DEN_W-1:0]    divisor,
    output logic [NUM_W-1:0]    quotient,
    output rcpd_pkg::div_stat_t stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             fit;

    assign rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fit     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                busy_reg <= (cnt_reg != CNT_W'(1));
                done_reg <= (cnt_reg == CNT_W'(1));
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    // one quotient bit per cycle, dividend shifted out of the quotient register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fit};
            rem_reg <= fit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

/* rtl/rc_pulse_to_differential_drive.sv */
// Radio-control stick pulses to a differential (arcade) motor drive. Each capture beat names
// a stick channel and a timer stamp; per channel, beats alternate between a rising edge that
// stores the start and a falling edge that stores the pulse width when the end is later than
// the start, and raises counter_clear when the other channel is not armed. Both widths are
// then mapped onto -position_limit..+position_limit, zeroed together inside the deadband or
// clamped, and mixed into left = (15v + 4h) / 10 and right = (15v - 4h) / 10, each split into
// forward and reverse duties. One beat yields one drive beat. The block takes one capture
// beat at a time; the shared bit-serial divider produces one quotient bit per cycle for
// each of the two maps, and a finished drive beat waits in the output register while the
// next capture beat is taken. A span with maximum not above minimum maps that channel to
// zero.
`default_nettype none

`include "rc_pulse_to_differential_drive_macros.svh"

module rc_pulse_to_differential_drive #(
    parameter int STAMP_BITS = rcpd_pkg::STAMP_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [rcpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rcpd_pkg::CFG_DATA_W-1:0]     cfg_data,
    rcpd_capture_if.sink                        capture,
    rcpd_drive_if.source                        drive
);

    localparam int IN_W   = rcpd_pkg::IN_W;
    localparam int DB_W   = rcpd_pkg::DB_W;
    localparam int POS_W  = rcpd_pkg::POS_W;
    localparam int DUTY_W = rcpd_pkg::DUTY_W;
    localparam int SUM_W  = rcpd_pkg::SUM_W;
    localparam int MAG_W  = rcpd_pkg::MAG_W;
    localparam int WW     = (STAMP_BITS > IN_W) ? STAMP_BITS : IN_W;
    localparam int NUMW   = WW + POS_W;
    localparam int PW     = NUMW + 2;
    localparam int PRODW  = WW + rcpd_pkg::CFG_DATA_W;

    // configuration
    logic [IN_W-1:0] vert_in_min_reg;
    logic [IN_W-1:0] vert_in_max_reg;
    logic [IN_W-1:0] horiz_in_min_reg;
    logic [IN_W-1:0] horiz_in_max_reg;
    logic [DB_W-1:0] dead_band_reg;
    logic [DB_W-1:0] position_limit_reg;

    // capture state
    logic                  vert_armed_reg;
    logic                  horiz_armed_reg;
    logic [STAMP_BITS-1:0] vert_start_reg;
    logic [STAMP_BITS-1:0] vert_width_reg;
    logic [STAMP_BITS-1:0] horiz_start_reg;
    logic [STAMP_BITS-1:0] horiz_width_reg;

    // sequencer and datapath
    rcpd_pkg::rcpd_state_t state_reg;
    rcpd_pkg::rcpd_state_t state_next;
    logic                  sel_reg;
    logic                  clr_reg;
    logic                  neg_reg;
    logic                  span_ok_reg;
    logic [IN_W-1:0]       span_reg;
    logic [PRODW-1:0]      prod_reg;
    logic signed [PW-1:0]  v_p_reg;
    logic signed [PW-1:0]  h_p_reg;
    logic signed [POS_W-1:0] v_pos_reg;
    logic signed [POS_W-1:0] h_pos_reg;
    logic [MAG_W-1:0]      l_mag_reg;
    logic [MAG_W-1:0]      r_mag_reg;
    logic                  l_pos_reg;
    logic                  r_pos_reg;
    logic [DUTY_W-1:0]     l_q_reg;

    // output register
    logic                  out_valid_reg;
    logic [DUTY_W-1:0]     lf_reg;
    logic [DUTY_W-1:0]     lr_reg;
    logic [DUTY_W-1:0]     rf_reg;
    logic [DUTY_W-1:0]     rr_reg;
    logic                  oclr_reg;
    logic signed [POS_W-1:0] ov_reg;
    logic signed [POS_W-1:0] oh_reg;

    logic                  accept;
    logic                  in_ready;
    logic                  out_load;
    logic [STAMP_BITS-1:0] stamp_in;

    logic [STAMP_BITS-1:0] w_sel;
    logic [IN_W-1:0]       lo_sel;
    logic [IN_W-1:0]       hi_sel;
    logic signed [WW:0]    diff;
    logic [WW:0]           diff_neg;
    logic [WW-1:0]         diff_mag;

    logic [WW-1:0]         mul_a;
    logic [rcpd_pkg::CFG_DATA_W-1:0] mul_b;
    logic [PRODW-1:0]      mul_p;

    logic                  div_start;
    logic [NUMW-1:0]       div_quo;
    rcpd_pkg::div_stat_t   div_stat;

    logic signed [PW-1:0]  q_s;
    logic signed [PW-1:0]  lim_p;
    logic signed [PW-1:0]  db_p;
    logic signed [PW-1:0]  p_map;
    logic signed [POS_W-1:0] lim_s;
    logic                  in_dead;
    logic signed [POS_W-1:0] v_clamp;
    logic signed [POS_W-1:0] h_clamp;

    logic signed [SUM_W-1:0] v16;
    logic signed [SUM_W-1:0] h16;
    logic signed [SUM_W-1:0] s_l;
    logic signed [SUM_W-1:0] s_r;
    logic [SUM_W-1:0]      s_l_neg;
    logic [SUM_W-1:0]      s_r_neg;
    logic [DUTY_W-1:0]     r_q;

    assign stamp_in = capture.stamp;
    assign accept   = capture.valid && in_ready;
    assign out_load = (state_reg == rcpd_pkg::ST_OUT) && (!out_valid_reg || drive.ready);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vert_in_min_reg    <= rcpd_pkg::VERT_IN_MIN_RST;
            vert_in_max_reg    <= rcpd_pkg::VERT_IN_MAX_RST;
            horiz_in_min_reg   <= rcpd_pkg::HORIZ_IN_MIN_RST;
            horiz_in_max_reg   <= rcpd_pkg::HORIZ_IN_MAX_RST;
            dead_band_reg      <= rcpd_pkg::DEAD_BAND_RST;
            position_limit_reg <= rcpd_pkg::POSITION_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rcpd_pkg::REG_VERT_IN_MIN:    vert_in_min_reg    <= cfg_data;
                rcpd_pkg::REG_VERT_IN_MAX:    vert_in_max_reg    <= cfg_data;
                rcpd_pkg::REG_HORIZ_IN_MIN:   horiz_in_min_reg   <= cfg_data;
                rcpd_pkg::REG_HORIZ_IN_MAX:   horiz_in_max_reg   <= cfg_data;
                rcpd_pkg::REG_DEAD_BAND:      dead_band_reg      <= cfg_data[DB_W-1:0];
                rcpd_pkg::REG_POSITION_LIMIT: position_limit_reg <= cfg_data[DB_W-1:0];
                default: ;
            endcase
        end
    end

    // capture edges: arm on rising, measure on falling
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vert_armed_reg  <= 1'b0;
            horiz_armed_reg <= 1'b0;
            vert_start_reg  <= '0;
            vert_width_reg  <= '0;
            horiz_start_reg <= '0;
            horiz_width_reg <= '0;
            clr_reg         <= 1'b0;
        end
        else if (accept)
        begin
            if (!capture.channel)
            begin
                if (!vert_armed_reg)
                begin
                    clr_reg        <= 1'b0;
                    vert_start_reg <= stamp_in;
                    vert_armed_reg <= 1'b1;
                end
                else
                begin
                    clr_reg        <= !horiz_armed_reg;
                    vert_armed_reg <= 1'b0;
                    if (stamp_in > vert_start_reg)
                    begin
                        vert_width_reg <= stamp_in - vert_start_reg;
                    end
                end
            end
            else
            begin
                if (!horiz_armed_reg)
                begin
                    clr_reg         <= 1'b0;
                    horiz_start_reg <= stamp_in;
                    horiz_armed_reg <= 1'b1;
                end
                else
                begin
                    clr_reg         <= !vert_armed_reg;
                    horiz_armed_reg <= 1'b0;
                    if (stamp_in > horiz_start_reg)
                    begin
                        horiz_width_reg <= stamp_in - horiz_start_reg;
                    end
                end
            end
        end
    end

    // map operands for the channel in work
    always_comb
    begin
        w_sel    = sel_reg ? horiz_width_reg : vert_width_reg;
        lo_sel   = sel_reg ? horiz_in_min_reg : vert_in_min_reg;
        hi_sel   = sel_reg ? horiz_in_max_reg : vert_in_max_reg;
        diff     = $signed({1'b0, WW'(w_sel)}) - $signed({1'b0, WW'(lo_sel)});
        diff_neg = -diff;
        diff_mag = diff[WW] ? diff_neg[WW-1:0] : diff[WW-1:0];
    end

    assign mul_p = PRODW'(mul_a) * PRODW'(mul_b);

    rcpd_div #(
        .NUM_W (NUMW),
        .DEN_W (IN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[NUMW-1:0]),
        .divisor  (span_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // signed quotient minus limit, deadband and clamp
    always_comb
    begin
        q_s     = $signed({2'b00, div_quo});
        lim_p   = $signed(PW'(position_limit_reg));
        db_p    = $signed(PW'(dead_band_reg));
        lim_s   = $signed({1'b0, position_limit_reg});
        p_map   = '0;
        if (span_ok_reg)
        begin
            p_map = (neg_reg ? -q_s : q_s) - lim_p;
        end
        in_dead = (v_p_reg > -db_p) && (v_p_reg < db_p)
                  && (h_p_reg > -db_p) && (h_p_reg < db_p);
        if (v_p_reg > lim_p)
        begin
            v_clamp = lim_s;
        end
        else if (v_p_reg < -lim_p)
        begin
            v_clamp = -lim_s;
        end
        else
        begin
            v_clamp = v_p_reg[POS_W-1:0];
        end
        if (h_p_reg > lim_p)
        begin
            h_clamp = lim_s;
        end
        else if (h_p_reg < -lim_p)
        begin
            h_clamp = -lim_s;
        end
        else
        begin
            h_clamp = h_p_reg[POS_W-1:0];
        end
    end

    // mix sums
    always_comb
    begin
        v16     = SUM_W'(v_pos_reg);
        h16     = SUM_W'(h_pos_reg);
        s_l     = v16 * rcpd_pkg::MIX_V_GAIN + h16 * rcpd_pkg::MIX_H_GAIN;
        s_r     = v16 * rcpd_pkg::MIX_V_GAIN - h16 * rcpd_pkg::MIX_H_GAIN;
        s_l_neg = -s_l;
        s_r_neg = -s_r;
        r_q     = prod_reg[rcpd_pkg::MIX_SHIFT +: DUTY_W];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcpd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = rcpd_pkg::ST_MUL;
                end
            end
            rcpd_pkg::ST_MUL:   state_next = rcpd_pkg::ST_START;
            rcpd_pkg::ST_START: state_next = rcpd_pkg::ST_WAIT;
            rcpd_pkg::ST_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = sel_reg ? rcpd_pkg::ST_SHAPE : rcpd_pkg::ST_MUL;
                end
            end
            rcpd_pkg::ST_SHAPE: state_next = rcpd_pkg::ST_SUM;
            rcpd_pkg::ST_SUM:   state_next = rcpd_pkg::ST_MIX_L;
            rcpd_pkg::ST_MIX_L: state_next = rcpd_pkg::ST_MIX_R;
            rcpd_pkg::ST_MIX_R: state_next = rcpd_pkg::ST_OUT;
            rcpd_pkg::ST_OUT:
            begin
                if (!out_valid_reg || drive.ready)
                begin
                    state_next = rcpd_pkg::ST_IDLE;
                end
            end
            default: state_next = rcpd_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        mul_a     = diff_mag;
        mul_b     = rcpd_pkg::CFG_DATA_W'({position_limit_reg, 1'b0});
        case (state_reg)
            rcpd_pkg::ST_IDLE:  in_ready = 1'b1;
            rcpd_pkg::ST_START: div_start = 1'b1;
            rcpd_pkg::ST_MIX_L:
            begin
                mul_a = WW'(l_mag_reg);
                mul_b = rcpd_pkg::MIX_RECIP;
            end
            rcpd_pkg::ST_MIX_R:
            begin
                mul_a = WW'(r_mag_reg);
                mul_b = rcpd_pkg::MIX_RECIP;
            end
            default: ;
        endcase
    end

    assign capture.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcpd_pkg::ST_IDLE;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                sel_reg <= 1'b0;
            end
            else if ((state_reg == rcpd_pkg::ST_WAIT) && div_stat.done)
            begin
                sel_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (drive.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rcpd_pkg::ST_MUL:
            begin
                prod_reg    <= mul_p;
                neg_reg     <= diff[WW];
                span_reg    <= hi_sel - lo_sel;
                span_ok_reg <= hi_sel > lo_sel;
            end
            rcpd_pkg::ST_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (sel_reg)
                    begin
                        h_p_reg <= p_map;
                    end
                    else
                    begin
                        v_p_reg <= p_map;
                    end
                end
            end
            rcpd_pkg::ST_SHAPE:
            begin
                v_pos_reg <= in_dead ? '0 : v_clamp;
                h_pos_reg <= in_dead ? '0 : h_clamp;
            end
            rcpd_pkg::ST_SUM:
            begin
                l_mag_reg <= s_l[SUM_W-1] ? s_l_neg[MAG_W-1:0] : s_l[MAG_W-1:0];
                r_mag_reg <= s_r[SUM_W-1] ? s_r_neg[MAG_W-1:0] : s_r[MAG_W-1:0];
                l_pos_reg <= !s_l[SUM_W-1] && (s_l != '0);
                r_pos_reg <= !s_r[SUM_W-1] && (s_r != '0);
            end
            rcpd_pkg::ST_MIX_L:
            begin
                prod_reg <= mul_p;
            end
            rcpd_pkg::ST_MIX_R:
            begin
                l_q_reg  <= prod_reg[rcpd_pkg::MIX_SHIFT +: DUTY_W];
                prod_reg <= mul_p;
            end
            default: ;
        endcase
        if (out_load)
        begin
            lf_reg   <= l_pos_reg ? l_q_reg : '0;
            lr_reg   <= l_pos_reg ? '0 : l_q_reg;
            rf_reg   <= r_pos_reg ? r_q : '0;
            rr_reg   <= r_pos_reg ? '0 : r_q;
            oclr_reg <= clr_reg;
            ov_reg   <= v_pos_reg;
            oh_reg   <= h_pos_reg;
        end
    end

    assign drive.valid          = out_valid_reg;
    assign drive.left_forward   = lf_reg;
    assign drive.left_reverse   = lr_reg;
    assign drive.right_forward  = rf_reg;
    assign drive.right_reverse  = rr_reg;
    assign drive.counter_clear  = oclr_reg;
    assign drive.vert_position  = ov_reg;
    assign drive.horiz_position = oh_reg;

    `RCPD_ASSERT_IMPLY(a_pos_range, out_valid_reg, (ov_reg <= lim_s) && (ov_reg >= -lim_s) && (oh_reg <= lim_s) && (oh_reg >= -lim_s), "position beyond limit")
    `RCPD_ASSERT_IMPLY(a_dir_excl, out_valid_reg, ((lf_reg == '0) || (lr_reg == '0)) && ((rf_reg == '0) || (rr_reg == '0)), "forward and reverse both driven")
    `RCPD_ASSERT_IMPLY(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
    `RCPD_ASSERT_NEXT(a_accept_busy, accept, !in_ready, "capture taken while an item is in work")

endmodule

`default_nettype wire

/* tb/tb_rc_pulse_to_differential_drive.sv */
`timescale 1ns / 100ps

module tb_rc_pulse_to_differential_drive;

    localparam logic CH_VERT  = 1'b0;
    localparam logic CH_HORIZ = 1'b1;

    typedef struct packed {
        logic [rcpd_pkg::DUTY_W-1:0]       left_forward;
        logic [rcpd_pkg::DUTY_W-1:0]       left_reverse;
        logic [rcpd_pkg::DUTY_W-1:0]       right_forward;
        logic [rcpd_pkg::DUTY_W-1:0]       right_reverse;
        logic                              counter_clear;
        logic signed [rcpd_pkg::POS_W-1:0] vert_position;
        logic signed [rcpd_pkg::POS_W-1:0] horiz_position;
    } drive_beat_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [rcpd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rcpd_pkg::CFG_DATA_W-1:0]  cfg_data;

    rcpd_capture_if cap ();
    rcpd_drive_if   drv ();

    rc_pulse_to_differential_drive DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .capture   (cap),
        .drive     (drv)
    );

    // Mixer settings as the block holds them
    logic [rcpd_pkg::IN_W-1:0] v_lo  = rcpd_pkg::VERT_IN_MIN_RST;
    logic [rcpd_pkg::IN_W-1:0] v_hi  = rcpd_pkg::VERT_IN_MAX_RST;
    logic [rcpd_pkg::IN_W-1:0] h_lo  = rcpd_pkg::HORIZ_IN_MIN_RST;
    logic [rcpd_pkg::IN_W-1:0] h_hi  = rcpd_pkg::HORIZ_IN_MAX_RST;
    logic [rcpd_pkg::DB_W-1:0] band  = rcpd_pkg::DEAD_BAND_RST;
    logic [rcpd_pkg::DB_W-1:0] limit = rcpd_pkg::POSITION_LIMIT_RST;

    // Stick capture state
    logic        v_armed = 1'b0;
    logic        h_armed = 1'b0;
    logic [15:0] v_rise  = '0;
    logic [15:0] v_pulse = '0;
    logic [15:0] h_rise  = '0;
    logic [15:0] h_pulse = '0;

    drive_beat_t expected_drive[$];
    int          mismatch_count = 0;
    int          drive_beats    = 0;
    int          sent_beats     = 0;
    int          burst_left     = 0;
    logic [15:0] stall_mask;
    int          stall_tick;

    always #10 clk = ~clk;

    function automatic longint map_pulse(input longint w, input longint lo,
                                         input longint hi, input longint lim);
        if (hi <= lo)
            return 0;
        return (w - lo) * 2 * lim / (hi - lo) - lim;
    endfunction

    function automatic drive_beat_t predict_drive(input logic ch, input logic [15:0] st);
        drive_beat_t r;
        longint      v;
        longint      h;
        longint      lim;
        longint      db;
        longint      left;
        longint      right;
        logic        clr;
        clr = 1'b0;
        if (ch == CH_VERT)
        begin
            if (!v_armed)
            begin
                v_rise  = st;
                v_armed = 1'b1;
            end
            else
            begin
                clr = !h_armed;
                if (st > v_rise)
                    v_pulse = st - v_rise;
                v_armed = 1'b0;
            end
        end
        else
        begin
            if (!h_armed)
            begin
                h_rise  = st;
                h_armed = 1'b1;
            end
            else
            begin
                clr = !v_armed;
                if (st > h_rise)
                    h_pulse = st - h_rise;
                h_armed = 1'b0;
            end
        end
        lim = limit;
        db  = band;
        v   = map_pulse(v_pulse, v_lo, v_hi, lim);
        h   = map_pulse(h_pulse, h_lo, h_hi, lim);
        if (v > -db && v < db && h > -db && h < db)
        begin
            v = 0;
            h = 0;
        end
        else
        begin
            v = (v > lim) ? lim : ((v < -lim) ? -lim : v);
            h = (h > lim) ? lim : ((h < -lim) ? -lim : h);
        end
        left  = (15 * v + 4 * h) / 10;
        right = (15 * v - 4 * h) / 10;
        r.left_forward   = (left > 0) ? rcpd_pkg::DUTY_W'(left) : '0;
        r.left_reverse   = (left > 0) ? '0 : rcpd_pkg::DUTY_W'(-left);
        r.right_forward  = (right > 0) ? rcpd_pkg::DUTY_W'(right) : '0;
        r.right_reverse  = (right > 0) ? '0 : rcpd_pkg::DUTY_W'(-right);
        r.counter_clear  = clr;
        r.vert_position  = rcpd_pkg::POS_W'(v);
        r.horiz_position = rcpd_pkg::POS_W'(h);
        return r;
    endfunction

    function automatic logic channel_armed(input logic ch);
        return (ch == CH_VERT) ? v_armed : h_armed;
    endfunction

    task automatic compare_field(input string name, input logic [10:0] got,
                                 input logic [10:0] want);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("drive beat %0d: %s expected %0d got %0d",
                         drive_beats, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_drive
        drive_beat_t want;
        if (rst_n && drv.valid && drv.ready)
        begin
            if (expected_drive.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("drive beat %0d arrived with nothing expected", drive_beats);
            end
            else
            begin
                want = expected_drive.pop_front();
                compare_field("left_forward", drv.left_forward, want.left_forward);
                compare_field("left_reverse", drv.left_reverse, want.left_reverse);
                compare_field("right_forward", drv.right_forward, want.right_forward);
                compare_field("right_reverse", drv.right_reverse, want.right_reverse);
                compare_field("counter_clear", {10'd0, drv.counter_clear},
                              {10'd0, want.counter_clear});
                compare_field("vert_position", drv.vert_position, want.vert_position);
                compare_field("horiz_position", drv.horiz_position, want.horiz_position);
            end
            drive_beats++;
        end
    end

    // Receiver stalls on a rotating mask, sometimes fully open
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 128 == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                stall_mask <= 16'hffff;
            else
                stall_mask <= 16'($urandom) | 16'h0001;
        end
        else
        begin
            stall_mask <= {stall_mask[0], stall_mask[15:1]};
        end
        drv.ready <= stall_mask[0];
    end

    task automatic send_capture(input logic ch, input logic [15:0] st);
        int gap;
        cap.valid   <= 1'b1;
        cap.channel <= ch;
        cap.stamp   <= st;
        @(posedge clk);
        while (!cap.ready)
            @(posedge clk);
        expected_drive.push_back(predict_drive(ch, st));
        sent_beats++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                cap.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold off until every drive beat is back and the block is quiet
    task automatic settle_idle();
        cap.valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rcpd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rcpd_pkg::CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            rcpd_pkg::REG_VERT_IN_MIN:    v_lo  = val;
            rcpd_pkg::REG_VERT_IN_MAX:    v_hi  = val;
            rcpd_pkg::REG_HORIZ_IN_MIN:   h_lo  = val;
            rcpd_pkg::REG_HORIZ_IN_MAX:   h_hi  = val;
            rcpd_pkg::REG_DEAD_BAND:      band  = val[rcpd_pkg::DB_W-1:0];
            rcpd_pkg::REG_POSITION_LIMIT: limit = val[rcpd_pkg::DB_W-1:0];
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_settings(input int vlo, input int vhi, input int hlo,
                                 input int hhi, input int db, input int lim);
        write_reg(rcpd_pkg::REG_VERT_IN_MIN, 16'(vlo));
        write_reg(rcpd_pkg::REG_VERT_IN_MAX, 16'(vhi));
        write_reg(rcpd_pkg::REG_HORIZ_IN_MIN, 16'(hlo));
        write_reg(rcpd_pkg::REG_HORIZ_IN_MAX, 16'(hhi));
        write_reg(rcpd_pkg::REG_DEAD_BAND, 16'(db));
        write_reg(rcpd_pkg::REG_POSITION_LIMIT, 16'(lim));
    endtask

    task automatic random_settings();
        int vlo;
        int hlo;
        vlo = $urandom_range(0, 60000);
        hlo = $urandom_range(0, 60000);
        load_settings(vlo,
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, vlo)
                                                  : vlo + $urandom_range(1, 5535),
                      hlo,
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, hlo)
                                                  : hlo + $urandom_range(1, 5535),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 60),
                      $urandom_range(1, 1023));
    endtask

    // Pick a pulse around the configured span; now and then end it too early
    function automatic void pulse_stamps(input logic ch, output logic [15:0] rise,
                                         output logic [15:0] fall);
        int lo;
        int hi;
        int span;
        int w;
        int r;
        lo = (ch == CH_VERT) ? v_lo : h_lo;
        hi = (ch == CH_VERT) ? v_hi : h_hi;
        if (hi > lo)
        begin
            span = hi - lo;
            w    = lo - span / 8 + $urandom_range(0, span + span / 4);
        end
        else
        begin
            w = $urandom_range(1, 65535);
        end
        if (w < 1)
            w = 1;
        if (w > 65535)
            w = 65535;
        r    = $urandom_range(0, 65535 - w);
        rise = 16'(r);
        fall = 16'(r + w);
        if ($urandom_range(0, 7) == 0)
            fall = 16'($urandom_range(0, r));
    endfunction

    task automatic send_stick_pulses(input bit both);
        logic        a;
        logic        b;
        logic [15:0] ra;
        logic [15:0] fa;
        logic [15:0] rb;
        logic [15:0] fb;
        a = 1'($urandom_range(0, 1));
        b = ~a;
        pulse_stamps(a, ra, fa);
        pulse_stamps(b, rb, fb);
        if (channel_armed(a))
            send_capture(a, 16'($urandom));
        if (both && channel_armed(b))
            send_capture(b, 16'($urandom));
        send_capture(a, ra);
        if (both)
        begin
            send_capture(b, rb);
            if ($urandom_range(0, 1) == 0)
            begin
                send_capture(a, fa);
                send_capture(b, fb);
            end
            else
            begin
                send_capture(b, fb);
                send_capture(a, fa);
            end
        end
        else
        begin
            send_capture(a, fa);
        end
    endtask

    task automatic test_capture_edges();
        send_capture(CH_VERT, 16'd0);
        send_capture(CH_VERT, 16'd1555);
        send_capture(CH_HORIZ, 16'd100);
        send_capture(CH_VERT, 16'd200);
        send_capture(CH_HORIZ, 16'd1637);
        send_capture(CH_VERT, 16'd200);
        send_capture(CH_VERT, 16'd65535);
        send_capture(CH_VERT, 16'd0);
        send_capture(CH_HORIZ, 16'd0);
        send_capture(CH_HORIZ, 16'd65535);
        send_capture(CH_VERT, 16'd1000);
        send_capture(CH_VERT, 16'd3065);
        send_capture(CH_VERT, 16'd5);
        send_capture(CH_VERT, 16'd1050);
        send_capture(CH_VERT, 16'd20);
        send_capture(CH_VERT, 16'd1575);
        // straddle the deadband edge on the horizontal stick
        send_capture(CH_HORIZ, 16'd7);
        send_capture(CH_HORIZ, 16'd1568);
        send_capture(CH_HORIZ, 16'd10);
        send_capture(CH_HORIZ, 16'd1572);
    endtask

    task automatic test_span_extremes();
        settle_idle();
        load_settings(0, 65535, 0, 65535, 0, 1023);
        send_capture(CH_VERT, 16'd0);
        send_capture(CH_VERT, 16'd65535);
        send_capture(CH_HORIZ, 16'd65535);
        send_capture(CH_HORIZ, 16'd0);
        send_capture(CH_HORIZ, 16'd1);
        send_capture(CH_HORIZ, 16'd2);
        settle_idle();
        load_settings(1000, 1001, 65534, 65535, 1023, 1);
        send_capture(CH_VERT, 16'd100);
        send_capture(CH_VERT, 16'd50);
        send_capture(CH_HORIZ, 16'd3);
        send_capture(CH_HORIZ, 16'd40003);
        settle_idle();
        load_settings(2000, 1000, 1500, 1500, 0, 1023);
        send_capture(CH_VERT, 16'd10);
        send_capture(CH_VERT, 16'd1510);
        send_capture(CH_HORIZ, 16'd10);
        send_capture(CH_HORIZ, 16'd1510);
    endtask

    task automatic test_random_traffic();
        int target;
        int pick;
        for (int phase = 0; phase < 6; phase++)
        begin
            settle_idle();
            case (phase)
                0: load_settings(rcpd_pkg::VERT_IN_MIN_RST, rcpd_pkg::VERT_IN_MAX_RST,
                                 rcpd_pkg::HORIZ_IN_MIN_RST, rcpd_pkg::HORIZ_IN_MAX_RST,
                                 rcpd_pkg::DEAD_BAND_RST, rcpd_pkg::POSITION_LIMIT_RST);
                1: load_settings(0, 65535, 0, 65535, 0, 1023);
                default: random_settings();
            endcase
            target = sent_beats + 100;
            while (sent_beats < target)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    send_capture(1'($urandom_range(0, 1)), 16'($urandom));
                else
                    send_stick_pulses(pick > 4);
            end
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cap.valid   = 1'b0;
        cap.channel = 1'b0;
        cap.stamp   = '0;
        drv.ready   = 1'b0;
        stall_mask  = 16'hffff;
        stall_tick  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_capture_edges();
        test_span_extremes();
        test_random_traffic();
        settle_idle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
